// ===== src/multi_channel_pipe_manager_unit_defines.svh =====
// Assertion macros for the pipe manager checker
`ifndef MULTI_CHANNEL_PIPE_MANAGER_UNIT_DEFINES_SVH
`define MULTI_CHANNEL_PIPE_MANAGER_UNIT_DEFINES_SVH
// implication checked on every clock edge outside reset
`define MCP_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("mcp check failed");
// implication whose consequent is checked in the following cycle
`define MCP_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("mcp check failed");
`endif

// ===== src/mcp_pkg.sv =====
// Package: command codes, status codes, record type and widths
package mcp_pkg;
  localparam int ChannelsDef  = 16;
  localparam int RingBytesDef = 65536;
  localparam int KEY_W  = 32;
  localparam int LEN_W  = 32;
  localparam int CNT_W  = 16;
  localparam int FILL_W = 17;
  localparam int OFF_W  = 16;
  localparam logic [16:0] ATOMIC_RESET = 17'd4096;

  typedef enum logic [3:0] {
    K_ALLOC = 4'd0, K_LOOKUP = 4'd1, K_FREE = 4'd2, K_ADD_RD = 4'd3,
    K_ADD_WR = 4'd4, K_DROP_RD = 4'd5, K_DROP_WR = 4'd6, K_WRITE = 4'd7,
    K_READ = 4'd8, K_CLEAR = 4'd9
  } kind_t;

  typedef enum logic [2:0] {
    ST_OK = 3'd0, ST_BADCH = 3'd1, ST_PIPE = 3'd2, ST_AGAIN = 3'd3, ST_NOTFOUND = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE, S_SCAN, S_READ, S_EXEC, S_CLEAR, S_OUT
  } state_t;

  typedef struct packed {
    logic              in_use;
    logic              writer_seen;
    logic [CNT_W-1:0]  readers;
    logic [CNT_W-1:0]  writers;
    logic [KEY_W-1:0]  key;
    logic [19:0]       head;
    logic [20:0]       fill;
  } rec_t;
  localparam int REC_W = $bits(rec_t);
endpackage

// ===== src/mcp_if.sv =====
// Valid/ready channel interface
interface mcp_if #(parameter type payload_t = logic) ();
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== src/mcp_ram.sv =====
// Generic single-port-write, registered-read RAM
module mcp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

// ===== src/multi_channel_pipe_manager_unit.sv =====
// Top level: pipe channel table held in one RAM, sequenced read-modify-write
//
//  channel | dir | payload
//  cmd     | in  | kind, channel, fifo_key, create, length
//  rsp     | out | status, channel_out, count, offset, wake, flags
//  cfg     | in  | atomic_limit (17 bits)
//
// Per-channel commands step through accept, record read, modify/write and result.
// Alloc and lookup scan the record RAM, one entry a cycle.
// Clear all sweeps the RAM; reset runs the same sweep with cmd not ready.
// Result held in a register until taken.
module multi_channel_pipe_manager_unit #(
  parameter int CHANNELS   = mcp_pkg::ChannelsDef,
  parameter int RING_BYTES = mcp_pkg::RingBytesDef
) (
  input logic clk,
  input logic rst,
  mcp_if.sink   cmd,
  mcp_if.source rsp,
  mcp_if.sink   cfg
);
  import mcp_pkg::*;
  localparam int AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam logic [20:0] RING_SZ = 21'(RING_BYTES);
  localparam logic [AW:0] LAST = (AW+1)'(CHANNELS - 1);

  state_t state, state_next;
  logic [16:0] atomic_limit;
  logic [3:0]  kind;
  logic [4:0]  chan;
  logic [31:0] key;
  logic        create;
  logic [31:0] len;
  logic [AW:0] idx;
  logic        found, free_seen, scan_rd;
  logic [AW:0] found_idx, free_idx;
  rec_t        found_rec;
  logic        we;
  logic [AW-1:0] waddr, raddr;
  rec_t        wrec, rrec;
  logic [REC_W-1:0] rdata;

  mcp_ram #(.WIDTH(REC_W), .DEPTH(CHANNELS)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wrec), .raddr(raddr), .rdata(rdata)
  );
  assign rrec = rec_t'(rdata);

  logic valid_ch;
  assign valid_ch = {27'd0, chan} < CHANNELS;
  assign cfg.ready = 1'b1;
  assign cmd.ready = (state == S_IDLE);

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) atomic_limit <= ATOMIC_RESET;
    else if (cfg.valid) atomic_limit <= cfg.data;
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: if (cmd.valid) begin
        if (cmd.data.kind == K_ALLOC || cmd.data.kind == K_LOOKUP) state_next = S_SCAN;
        else if (cmd.data.kind == K_CLEAR) state_next = S_CLEAR;
        else state_next = S_READ;
      end
      S_SCAN:  if (!scan_rd && idx == LAST + 1'b1) state_next = S_EXEC;
      S_READ:  state_next = S_EXEC;
      S_EXEC:  state_next = S_OUT;
      S_CLEAR: if (idx == LAST) state_next = (kind == K_CLEAR) ? S_OUT : S_IDLE;
      S_OUT:   if (rsp.ready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // record modify
  rec_t  m;
  logic  m_we;
  status_t st;
  logic [3:0] chout;
  logic [16:0] cnt;
  logic [15:0] offs;
  logic  wk, flag_ok;
  logic [20:0] room, take;
  logic [AW-1:0] sel;
  always_comb begin
    m = rrec; m_we = 1'b0; st = ST_OK; chout = '0; cnt = '0; offs = '0; wk = 1'b0;
    flag_ok = valid_ch; sel = chan[AW-1:0];
    room = RING_SZ - rrec.fill;
    take = '0;
    case (kind)
      K_ALLOC, K_LOOKUP: begin
        flag_ok = 1'b0;
        // a zero key never matches on lookup
        if (kind == K_LOOKUP && key != 0 && found) begin
          flag_ok = 1'b1; sel = found_idx[AW-1:0]; m = found_rec;
        end else if (free_seen && (kind == K_ALLOC || (key != 0 && create))) begin
          flag_ok = 1'b1; sel = free_idx[AW-1:0]; m_we = 1'b1;
          m = '0; m.in_use = 1'b1; m.key = key; m.writer_seen = (key == 0);
        end else st = ST_NOTFOUND;
        if (flag_ok) chout = 4'(sel);
      end
      K_FREE: if (valid_ch) begin m = '0; m_we = 1'b1; end else st = ST_BADCH;
      K_ADD_RD, K_ADD_WR, K_DROP_RD, K_DROP_WR: begin
        if (!valid_ch || !rrec.in_use) st = ST_BADCH;
        else begin
          m_we = 1'b1;
          if (kind == K_ADD_RD && rrec.readers != '1) m.readers = rrec.readers + 1'b1;
          if (kind == K_ADD_WR) begin
            if (rrec.writers != '1) m.writers = rrec.writers + 1'b1;
            m.writer_seen = 1'b1;
          end
          if (kind == K_DROP_RD && rrec.readers != 0) m.readers = rrec.readers - 1'b1;
          if (kind == K_DROP_WR && rrec.writers != 0) m.writers = rrec.writers - 1'b1;
          if ((kind == K_DROP_RD || kind == K_DROP_WR) && m.readers == 0 && m.writers == 0)
            m = '0;
        end
      end
      K_WRITE: if (len != 0) begin
        if (!valid_ch || !rrec.in_use) st = ST_BADCH;
        else if (rrec.readers == 0) st = ST_PIPE;
        else if (room == 0 || ({15'd0, len} <= {30'd0, atomic_limit} &&
                 {11'd0, room} < len)) st = ST_AGAIN;
        else begin
          take = ({11'd0, room} < len) ? room : len[20:0];
          offs = 16'((rrec.head + rrec.fill) & 21'(RING_BYTES - 1));
          m.fill = rrec.fill + take; m_we = 1'b1;
          cnt = 17'(take); wk = 1'b1;
        end
      end
      K_READ: if (len != 0) begin
        if (!valid_ch || !rrec.in_use) st = ST_BADCH;
        else begin
          take = ({11'd0, rrec.fill} < len) ? rrec.fill : len[20:0];
          if (take != 0) begin
            offs = 16'(rrec.head);
            m.head = 20'((21'(rrec.head) + take) & 21'(RING_BYTES - 1));
            m.fill = rrec.fill - take; m_we = 1'b1;
            cnt = 17'(take); wk = 1'b1;
          end else if (!(rrec.writers == 0 && (rrec.key == 0 || rrec.writer_seen)))
            st = ST_AGAIN;
        end
      end
      default: ;
    endcase
  end

  // RAM port control
  always_comb begin
    we = 1'b0; waddr = sel; wrec = m;
    raddr = chan[AW-1:0];
    if (state == S_SCAN) raddr = idx[AW-1:0];
    if (state == S_IDLE) raddr = cmd.data.channel[AW-1:0];
    if (state == S_EXEC) begin we = m_we; raddr = sel; end
    if (state == S_CLEAR) begin we = 1'b1; waddr = idx[AW-1:0]; wrec = '0; end
  end

  // flags from the record after the step (m is the new value of sel)
  logic rd_f, wr_f, hu_f, hr_f;
  assign rd_f = flag_ok && m.in_use && (m.fill != 0 || m.writers == 0);
  assign wr_f = flag_ok && m.in_use && m.readers != 0 && m.fill < RING_SZ;
  assign hu_f = flag_ok && m.in_use && m.writers == 0;
  assign hr_f = flag_ok && m.in_use && m.readers != 0;

  // sequencing registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR; idx <= '0; rsp.valid <= 1'b0; scan_rd <= 1'b0;
      kind <= 4'(K_FREE);
    end else begin
      state <= state_next;
      case (state)
        S_IDLE: if (cmd.valid) begin
          kind <= cmd.data.kind; chan <= cmd.data.channel; key <= cmd.data.fifo_key;
          create <= cmd.data.create; len <= cmd.data.length;
          idx <= '0; found <= 1'b0; free_seen <= 1'b0; scan_rd <= 1'b1;
        end
        S_SCAN: begin
          scan_rd <= 1'b0;
          if (scan_rd || idx != LAST + 1'b1) idx <= idx + 1'b1;
          if (!scan_rd) begin
            if (rrec.in_use && rrec.key == key && !found) begin
              found <= 1'b1; found_idx <= idx - 1'b1; found_rec <= rrec;
            end
            if (!rrec.in_use && !free_seen) begin
              free_seen <= 1'b1; free_idx <= idx - 1'b1;
            end
          end
        end
        S_EXEC: begin
          rsp.valid <= 1'b1;
          rsp.data <= '{status: st, channel_out: chout, count: cnt, offset: offs, wake: wk,
                        readable: rd_f, writable: wr_f, hangup: hu_f, has_readers: hr_f};
        end
        S_CLEAR: begin
          if (idx == LAST) begin
            idx <= '0;
            // every channel is unused after clear all, so no flag is set
            if (kind == K_CLEAR) begin
              rsp.valid <= 1'b1;
              rsp.data <= '{status: ST_OK, channel_out: 4'd0, count: 17'd0, offset: 16'd0,
                            wake: 1'b0, readable: 1'b0, writable: 1'b0, hangup: 1'b0,
                            has_readers: 1'b0};
            end
          end else idx <= idx + 1'b1;
        end
        S_OUT: if (rsp.ready) rsp.valid <= 1'b0;
        default: ;
      endcase
    end
  end
endmodule

// ===== src/mcp_checker.sv =====
// Port-level checker for the pipe manager, bound to the top level
`include "multi_channel_pipe_manager_unit_defines.svh"
module mcp_checker (
  input logic clk,
  input logic rst,
  input logic cmd_valid, cmd_ready, rsp_valid, rsp_ready,
  input logic [2:0] status,
  input logic [16:0] count,
  input logic wake
);
  `MCP_ASSERT_IMP(a_no_cmd_while_rsp, rsp_valid, !cmd_ready)
  `MCP_ASSERT_IMP(a_wake_count, rsp_valid && wake, count != 0 && status == 3'd0)
  `MCP_ASSERT_IMP(a_status_range, rsp_valid, status <= 3'd4)
  `MCP_ASSERT_NXT(a_accept_busy, cmd_valid && cmd_ready, !cmd_ready)
endmodule

bind multi_channel_pipe_manager_unit mcp_checker u_chk (
  .clk(clk), .rst(rst), .cmd_valid(cmd.valid), .cmd_ready(cmd.ready),
  .rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .status(rsp.data.status),
  .count(rsp.data.count), .wake(rsp.data.wake)
);

// ===== dv/mcp_tb_pkg.sv =====
// Testbench types: command and result transaction layouts for the pipe manager
`timescale 1ns / 1ps
package mcp_tb_pkg;
  import mcp_pkg::*;

  typedef struct packed {
    kind_t       kind;
    logic [4:0]  channel;
    logic [31:0] fifo_key;
    logic        create;
    logic [31:0] length;
  } pipe_cmd_t;

  typedef struct packed {
    status_t     status;
    logic [3:0]  channel_out;
    logic [16:0] count;
    logic [15:0] offset;
    logic        wake;
    logic        readable;
    logic        writable;
    logic        hangup;
    logic        has_readers;
  } pipe_rsp_t;

  typedef logic [16:0] limit_t;
endpackage

// ===== dv/mcp_pipe_checker.sv =====
// Checker: tracks the channel table, predicts each result and compares it
`timescale 1ns / 1ps
module mcp_pipe_checker
  import mcp_pkg::*;
  import mcp_tb_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      cmd_valid,
  input  logic      cmd_ready,
  input  pipe_cmd_t cmd_data,
  input  logic      rsp_valid,
  input  logic      rsp_ready,
  input  pipe_rsp_t rsp_data,
  input  logic      cfg_valid,
  input  logic      cfg_ready,
  input  limit_t    cfg_data,
  output int        fails,
  output int        pending
);
  localparam int NCH  = ChannelsDef;
  localparam int RING = RingBytesDef;

  // shadow channel table
  bit          used_q   [NCH];
  bit          wseen_q  [NCH];
  int unsigned readers_q[NCH];
  int unsigned writers_q[NCH];
  bit [31:0]   key_q    [NCH];
  int unsigned head_q   [NCH];
  int unsigned fill_q   [NCH];
  int unsigned atomic_lim;

  pipe_rsp_t expected_rsp_q[$];
  int        n_fail;

  function automatic void wipe_channel(int c);
    used_q[c] = 0; wseen_q[c] = 0; readers_q[c] = 0; writers_q[c] = 0;
    key_q[c] = '0; head_q[c] = 0; fill_q[c] = 0;
  endfunction

  // claim the lowest unused channel and return it, or -1 when the table is full
  function automatic int claim_channel(bit [31:0] key);
    for (int c = 0; c < NCH; c++) begin
      if (!used_q[c]) begin
        wipe_channel(c);
        used_q[c]  = 1;
        key_q[c]   = key;
        wseen_q[c] = (key == 0);
        return c;
      end
    end
    return -1;
  endfunction

  function automatic pipe_rsp_t predict_pipe_rsp(pipe_cmd_t c);
    pipe_rsp_t   r;
    int          got, flag, ch;
    bit          valid, used;
    longint      len, room, take;
    r = '0;
    r.status = ST_OK;
    flag = -1;
    ch = c.channel;
    valid = ch < NCH;
    used = valid && used_q[ch];
    len = c.length;
    case (c.kind)
      K_ALLOC, K_LOOKUP: begin
        got = -1;
        if (c.kind == K_ALLOC) begin
          got = claim_channel(c.fifo_key);
        end else if (c.fifo_key != 0) begin
          for (int i = 0; i < NCH && got < 0; i++)
            if (used_q[i] && key_q[i] == c.fifo_key) got = i;
          if (got < 0 && c.create) got = claim_channel(c.fifo_key);
        end
        if (got < 0) r.status = ST_NOTFOUND;
        else begin
          r.channel_out = got[3:0];
          flag = got;
        end
      end
      K_FREE: begin
        if (valid) begin
          wipe_channel(ch);
          flag = ch;
        end else r.status = ST_BADCH;
      end
      K_ADD_RD, K_ADD_WR, K_DROP_RD, K_DROP_WR: begin
        if (!used) r.status = ST_BADCH;
        else begin
          flag = ch;
          case (c.kind)
            K_ADD_RD: if (readers_q[ch] < 16'hFFFF) readers_q[ch]++;
            K_ADD_WR: begin
              if (writers_q[ch] < 16'hFFFF) writers_q[ch]++;
              wseen_q[ch] = 1;
            end
            default: begin
              if (c.kind == K_DROP_RD) begin
                if (readers_q[ch] > 0) readers_q[ch]--;
              end else if (writers_q[ch] > 0) writers_q[ch]--;
              if (readers_q[ch] == 0 && writers_q[ch] == 0) wipe_channel(ch);
            end
          endcase
        end
      end
      K_WRITE: begin
        if (valid) flag = ch;
        if (len == 0) ;
        else if (!used) r.status = ST_BADCH;
        else if (readers_q[ch] == 0) r.status = ST_PIPE;
        else begin
          room = RING - fill_q[ch];
          if (room == 0 || (len <= atomic_lim && room < len)) r.status = ST_AGAIN;
          else begin
            take = (len < room) ? len : room;
            r.offset = 16'((head_q[ch] + fill_q[ch]) % RING);
            fill_q[ch] += int'(take);
            r.count = 17'(take);
            r.wake = 1;
          end
        end
      end
      K_READ: begin
        if (valid) flag = ch;
        if (len == 0) ;
        else if (!used) r.status = ST_BADCH;
        else begin
          take = (len < fill_q[ch]) ? len : fill_q[ch];
          if (take != 0) begin
            r.offset = 16'(head_q[ch]);
            head_q[ch] = int'((head_q[ch] + take) % RING);
            fill_q[ch] -= int'(take);
            r.count = 17'(take);
            r.wake = 1;
          end else if (!(writers_q[ch] == 0 && (key_q[ch] == 0 || wseen_q[ch]))) begin
            r.status = ST_AGAIN;
          end
        end
      end
      K_CLEAR: begin
        for (int i = 0; i < NCH; i++) wipe_channel(i);
        if (valid) flag = ch;
      end
      default: if (valid) flag = ch;
    endcase
    // state flags of the addressed or chosen channel after the command
    if (flag >= 0 && used_q[flag]) begin
      r.readable    = fill_q[flag] != 0 || writers_q[flag] == 0;
      r.writable    = readers_q[flag] != 0 && fill_q[flag] < RING;
      r.hangup      = writers_q[flag] == 0;
      r.has_readers = readers_q[flag] != 0;
    end
    return r;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("%0t: result %s mismatch: got %0d expected %0d", $realtime, what, got, want);
    n_fail++;
  endtask

  function automatic void reset_table();
    atomic_lim = 32'(ATOMIC_RESET);
    for (int i = 0; i < NCH; i++) wipe_channel(i);
  endfunction

  initial begin
    n_fail = 0;
    reset_table();
  end

  // observe the three channels on every edge
  always @(posedge clk) begin
    pipe_rsp_t w;
    if (rst) begin
      reset_table();
      expected_rsp_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) atomic_lim = 32'(cfg_data);
      if (rsp_valid && rsp_ready) begin
        if (expected_rsp_q.size() == 0) begin
          report_mismatch("presence", 1, 0);
        end else begin
          w = expected_rsp_q.pop_front();
          if (rsp_data.status != w.status) report_mismatch("status", rsp_data.status, w.status);
          if (rsp_data.channel_out != w.channel_out)
            report_mismatch("channel_out", rsp_data.channel_out, w.channel_out);
          if (rsp_data.count != w.count) report_mismatch("count", rsp_data.count, w.count);
          if (rsp_data.offset != w.offset) report_mismatch("offset", rsp_data.offset, w.offset);
          if (rsp_data.wake != w.wake) report_mismatch("wake", rsp_data.wake, w.wake);
          if (rsp_data.readable != w.readable)
            report_mismatch("readable", rsp_data.readable, w.readable);
          if (rsp_data.writable != w.writable)
            report_mismatch("writable", rsp_data.writable, w.writable);
          if (rsp_data.hangup != w.hangup) report_mismatch("hangup", rsp_data.hangup, w.hangup);
          if (rsp_data.has_readers != w.has_readers)
            report_mismatch("has_readers", rsp_data.has_readers, w.has_readers);
        end
      end
      if (cmd_valid && cmd_ready) expected_rsp_q.push_back(predict_pipe_rsp(cmd_data));
    end
    fails   <= n_fail;
    pending <= expected_rsp_q.size();
  end
endmodule

// ===== dv/tb_multi_channel_pipe_manager_unit.sv =====
// Testbench top: clock, reset, command stimulus, result back-pressure, verdict
`timescale 1ns / 1ps
module tb_multi_channel_pipe_manager_unit;
  import mcp_pkg::*;
  import mcp_tb_pkg::*;

  localparam int CYCLE_LIMIT = 600000;
  localparam int ITEMS_PER_PHASE = 316;

  logic clk;
  logic rst;
  int   fails, pending;
  int   send_idle_pct, recv_idle_pct;
  bit   long_stall_req;
  int   cycles;

  mcp_if #(.payload_t(pipe_cmd_t)) cmd_ch ();
  mcp_if #(.payload_t(pipe_rsp_t)) rsp_ch ();
  mcp_if #(.payload_t(limit_t))    cfg_ch ();

  multi_channel_pipe_manager_unit dut (
    .clk (clk),
    .rst (rst),
    .cmd (cmd_ch),
    .rsp (rsp_ch),
    .cfg (cfg_ch)
  );

  mcp_pipe_checker checker_i (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_ch.valid),
    .cmd_ready (cmd_ch.ready),
    .cmd_data  (cmd_ch.data),
    .rsp_valid (rsp_ch.valid),
    .rsp_ready (rsp_ch.ready),
    .rsp_data  (rsp_ch.data),
    .cfg_valid (cfg_ch.valid),
    .cfg_ready (cfg_ch.ready),
    .cfg_data  (cfg_ch.data),
    .fails     (fails),
    .pending   (pending)
  );

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  // cycle watchdog
  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  // result back-pressure, with an occasional long hold-off
  initial begin
    rsp_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (long_stall_req) begin
        rsp_ch.ready <= 1'b0;
        repeat (400) @(posedge clk);
        long_stall_req = 0;
      end
      rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // offer one command transaction; valid is left high when it returns
  task automatic send_cmd(pipe_cmd_t c);
    if ($urandom_range(99) < send_idle_pct) begin
      cmd_ch.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    cmd_ch.valid <= 1'b1;
    cmd_ch.data  <= c;
    do @(posedge clk); while (!cmd_ch.ready);
  endtask

  task automatic wait_drained();
    cmd_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  task automatic write_limit(limit_t v);
    wait_drained();
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= v;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
  endtask

  function automatic pipe_cmd_t mk(kind_t k, int ch, logic [31:0] key, bit cr,
                                   logic [31:0] len);
    pipe_cmd_t c;
    c.kind = k; c.channel = 5'(ch); c.fifo_key = key; c.create = cr; c.length = len;
    return c;
  endfunction

  // random command biased towards a few live channels and keys
  function automatic pipe_cmd_t rand_cmd();
    pipe_cmd_t   c;
    int          r;
    logic [3:0]  k;
    r = $urandom_range(99);
    if (r < 10) k = K_ALLOC;
    else if (r < 18) k = K_LOOKUP;
    else if (r < 22) k = K_FREE;
    else if (r < 32) k = K_ADD_RD;
    else if (r < 40) k = K_ADD_WR;
    else if (r < 45) k = K_DROP_RD;
    else if (r < 50) k = K_DROP_WR;
    else if (r < 72) k = K_WRITE;
    else if (r < 93) k = K_READ;
    else if (r < 94) k = K_CLEAR;
    else k = 4'($urandom_range(15));
    c.kind = kind_t'(k);
    r = $urandom_range(99);
    if (r < 85) c.channel = 5'($urandom_range(5));
    else if (r < 93) c.channel = 5'($urandom_range(15));
    else c.channel = 5'($urandom_range(31, 16));
    r = $urandom_range(9);
    c.fifo_key = (r < 4) ? 32'd0 : (r < 8) ? 32'($urandom_range(3, 1)) : $urandom;
    c.create = 1'($urandom_range(1));
    r = $urandom_range(99);
    if (r < 5) c.length = 0;
    else if (r < 40) c.length = $urandom_range(256, 1);
    else if (r < 60) c.length = $urandom_range(8192, 2048);
    else if (r < 85) c.length = $urandom_range(70000, 8192);
    else c.length = $urandom;
    return c;
  endfunction

  initial begin
    limit_t limits[6];
    rst = 1'b1;
    long_stall_req = 0;
    send_idle_pct = 28;
    recv_idle_pct = 67;
    cmd_ch.valid <= 1'b0;
    cmd_ch.data  <= '0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.data  <= '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // directed: every command, bad and unused channels, limits of fields
    send_cmd(mk(K_CLEAR, 0, 0, 0, 0));
    send_cmd(mk(K_ALLOC, 0, 0, 0, 0));
    send_cmd(mk(K_READ, 0, 0, 0, 10));
    send_cmd(mk(K_WRITE, 0, 0, 0, 10));
    send_cmd(mk(K_ADD_RD, 0, 0, 0, 0));
    send_cmd(mk(K_WRITE, 0, 0, 0, 0));
    send_cmd(mk(K_WRITE, 20, 0, 0, 5));
    send_cmd(mk(K_WRITE, 0, 0, 0, 4096));
    send_cmd(mk(K_WRITE, 0, 0, 0, 32'hFFFF_FFFF));
    send_cmd(mk(K_WRITE, 0, 0, 0, 1));
    send_cmd(mk(K_READ, 0, 0, 0, 100));
    send_cmd(mk(K_READ, 0, 0, 0, 32'hFFFF_FFFF));
    send_cmd(mk(K_READ, 31, 0, 0, 0));
    send_cmd(mk(K_LOOKUP, 0, 0, 1, 0));
    send_cmd(mk(K_LOOKUP, 0, 32'hFFFF_FFFF, 0, 0));
    send_cmd(mk(K_LOOKUP, 0, 32'hFFFF_FFFF, 1, 0));
    send_cmd(mk(K_LOOKUP, 0, 32'hFFFF_FFFF, 0, 0));
    send_cmd(mk(K_READ, 1, 0, 0, 8));
    send_cmd(mk(K_ADD_WR, 1, 0, 0, 0));
    send_cmd(mk(K_DROP_WR, 1, 0, 0, 0));
    send_cmd(mk(K_READ, 1, 0, 0, 8));
    send_cmd(mk(K_DROP_RD, 0, 0, 0, 0));
    send_cmd(mk(K_FREE, 31, 0, 0, 0));
    send_cmd(mk(K_FREE, 9, 0, 0, 0));
    send_cmd(mk(kind_t'(4'hF), 3, 0, 0, 0));

    // random phases across atomic limit settings and idling patterns
    limits = '{17'd0, 17'd65536, 17'd1, 17'd4096, 17'($urandom_range(65536)), 17'd65535};
    for (int p = 0; p < 6; p++) begin
      write_limit(limits[p]);
      send_idle_pct = (p < 2) ? 28 : (p < 4) ? 67 : 0;
      recv_idle_pct = (p < 2) ? 67 : (p < 4) ? 28 : 0;
      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        if (i == 100 && (p == 1 || p == 4)) long_stall_req = 1;
        send_cmd(rand_cmd());
      end
    end

    wait_drained();
    repeat (20) @(posedge clk);
    if (fails == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule

// ===== files.f =====
+incdir+src
src/mcp_pkg.sv
src/mcp_if.sv
src/mcp_ram.sv
src/multi_channel_pipe_manager_unit.sv
src/mcp_checker.sv
dv/mcp_tb_pkg.sv
dv/mcp_pipe_checker.sv
dv/tb_multi_channel_pipe_manager_unit.sv
